// File: rtl/dbs_pkg.sv
// Shared types and constants of the depth bilinear sampler.
`default_nettype none

package dbs_pkg;

    // Width of each signed fixed-point coordinate field
    localparam int COORD_BITS = 21;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Bit positions in the result tuser
    localparam int USER_OUT_OF_IMAGE  = 0;
    localparam int USER_USED_FALLBACK = 1;
    localparam int USER_BITS          = 2;

    // Per-request classification from the front stage
    typedef struct packed {
        logic       out_of_image;
        logic       any_inf;
        logic [2:0] finite_cnt;
    } t_front_flags;

endpackage

`default_nettype wire

// File: rtl/dbs_front.sv
// Front stage of the sampler: bounds check, infinite-corner detection and blend weights.
`default_nettype none

module dbs_front #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int DEPTH_BITS      = 24,
    parameter int DIM_BITS        = 12
) (
    input  wire logic signed [dbs_pkg::COORD_BITS-1:0] i_x_pos,
    input  wire logic signed [dbs_pkg::COORD_BITS-1:0] i_y_pos,
    input  wire logic [3:0][DEPTH_BITS-1:0]            i_depth,
    input  wire logic [DIM_BITS:0]                     i_image_width,
    input  wire logic [DIM_BITS:0]                     i_image_height,
    output dbs_pkg::t_front_flags                      o_flags,
    output logic [3:0][DEPTH_BITS-1:0]                 o_depth_fin,
    output logic [3:0][2*COORD_FRAC_BITS:0]            o_weight
);

    localparam int W_LIM = DIM_BITS + 1 + COORD_FRAC_BITS;
    localparam int W_POS = dbs_pkg::COORD_BITS - 1;
    localparam int W_CMP = (W_LIM > W_POS) ? W_LIM : W_POS;
    localparam int W_WT  = 2 * COORD_FRAC_BITS + 1;
    localparam logic [COORD_FRAC_BITS:0] FRAC_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};

    logic [DIM_BITS:0]          width_m1;
    logic [DIM_BITS:0]          height_m1;
    logic [W_CMP-1:0]           lim_x;
    logic [W_CMP-1:0]           lim_y;
    logic [W_CMP-1:0]           pos_x;
    logic [W_CMP-1:0]           pos_y;
    logic                       outside_x;
    logic                       outside_y;
    logic [COORD_FRAC_BITS:0]   fx;
    logic [COORD_FRAC_BITS:0]   fy;
    logic [COORD_FRAC_BITS:0]   gx;
    logic [COORD_FRAC_BITS:0]   gy;
    logic [3:0]                 inf;

    // Last valid position is (dim-1) in whole pixels
    assign width_m1  = i_image_width - (DIM_BITS+1)'(1);
    assign height_m1 = i_image_height - (DIM_BITS+1)'(1);
    assign lim_x     = W_CMP'({width_m1, {COORD_FRAC_BITS{1'b0}}});
    assign lim_y     = W_CMP'({height_m1, {COORD_FRAC_BITS{1'b0}}});
    assign pos_x     = W_CMP'(i_x_pos[W_POS-1:0]);
    assign pos_y     = W_CMP'(i_y_pos[W_POS-1:0]);

    assign outside_x = i_x_pos[dbs_pkg::COORD_BITS-1] || (i_image_width == '0)
                       || (pos_x > lim_x);
    assign outside_y = i_y_pos[dbs_pkg::COORD_BITS-1] || (i_image_height == '0)
                       || (pos_y > lim_y);

    assign fx = {1'b0, i_x_pos[COORD_FRAC_BITS-1:0]};
    assign fy = {1'b0, i_y_pos[COORD_FRAC_BITS-1:0]};
    assign gx = FRAC_ONE - fx;
    assign gy = FRAC_ONE - fy;

    // Corner order: top-left, top-right, bottom-left, bottom-right
    assign o_weight[0] = W_WT'(gx) * W_WT'(gy);
    assign o_weight[1] = W_WT'(fx) * W_WT'(gy);
    assign o_weight[2] = W_WT'(gx) * W_WT'(fy);
    assign o_weight[3] = W_WT'(fx) * W_WT'(fy);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            inf[i]            = &i_depth[i];
            o_depth_fin[i]    = inf[i] ? '0 : i_depth[i];
        end
    end

    assign o_flags.out_of_image = outside_x || outside_y;
    assign o_flags.any_inf      = |inf;
    assign o_flags.finite_cnt   = {2'b00, ~inf[0]} + {2'b00, ~inf[1]}
                                + {2'b00, ~inf[2]} + {2'b00, ~inf[3]};

endmodule

`default_nettype wire

// File: rtl/depth_bilinear_sampler_unit.sv
// Top level of the depth bilinear sampler: configuration, four-stage pipeline, stream ports.
`default_nettype none

// Samples a depth map at one signed fixed-point (x, y) per request, given the four
// corner depths around floor(x), floor(y). A depth of all ones is infinite. A position
// outside 0..width-1 / 0..height-1 gives depth 0 with out_of_image set. If any corner is
// infinite the result is the truncated mean of the finite corners (all ones if none is
// finite) with used_fallback set; otherwise exact bilinear interpolation truncated once.
// One request per cycle is sustained while the master side is ready; a request's result
// moves through the stages front/weights, corner products, accumulate and divide-by-3
// multiply, then select into the output register. Each stage has its own valid bit and
// the ready chain lets bubbles close, so a stalled output only holds the stages behind
// it once they are full. No clearing pass after reset. The user must write image width and
// height through the cfg port only while the block is idle; the block does not enforce it.
module depth_bilinear_sampler_unit #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int DEPTH_BITS      = 24,
    parameter int DIM_BITS        = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_addr,
    input  wire logic [DIM_BITS:0]    i_cfg_wdata,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // x_pos, y_pos, depth_top_left, depth_top_right, depth_bottom_left,
    // depth_bottom_right, zero pad
    input  wire logic [((2*dbs_pkg::COORD_BITS+4*DEPTH_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // depth_out, zero pad
    output logic [((DEPTH_BITS+7)/8)*8-1:0] m_axis_tdata,
    // out_of_image, used_fallback
    output logic [dbs_pkg::USER_BITS-1:0]   m_axis_tuser
);

    localparam int CB     = dbs_pkg::COORD_BITS;
    localparam int W_OUT  = ((DEPTH_BITS + 7) / 8) * 8;
    localparam int W_WT   = 2 * COORD_FRAC_BITS + 1;        // blend weight
    localparam int W_PROD = DEPTH_BITS + W_WT;              // corner * weight
    localparam int W_ACC  = W_PROD + 2;                     // sum of four products
    localparam int W_SUM  = DEPTH_BITS + 2;                 // sum of finite corners
    // floor(s/3) = (s * ceil(2^K/3)) >> K holds for every s below 2^W_SUM
    localparam int K3     = W_SUM + 1;
    localparam int W_D3P  = W_SUM + K3;
    localparam logic [K3-1:0] DIV3_MUL = K3'(((64'd1 << K3) + 64'd2) / 64'd3);

    // ---------------------------------------------------------------- config
    logic [DIM_BITS:0] r_image_width;
    logic [DIM_BITS:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= {1'b1, {DIM_BITS{1'b0}}};
            r_image_height <= {1'b1, {DIM_BITS{1'b0}}};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dbs_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                dbs_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic signed [CB-1:0]         in_x;
    logic signed [CB-1:0]         in_y;
    logic [3:0][DEPTH_BITS-1:0]   in_depth;
    dbs_pkg::t_front_flags        n_flags1;
    logic [3:0][DEPTH_BITS-1:0]   n_depth1;
    logic [3:0][W_WT-1:0]         n_weight1;

    assign in_x = s_axis_tdata[CB-1:0];
    assign in_y = s_axis_tdata[2*CB-1:CB];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_depth[i] = s_axis_tdata[2*CB + i*DEPTH_BITS +: DEPTH_BITS];
        end
    end

    dbs_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DEPTH_BITS      (DEPTH_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_dbs_front (
        .i_x_pos        (in_x),
        .i_y_pos        (in_y),
        .i_depth        (in_depth),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_flags        (n_flags1),
        .o_depth_fin    (n_depth1),
        .o_weight       (n_weight1)
    );

    dbs_pkg::t_front_flags        r_flags1;
    logic [3:0][DEPTH_BITS-1:0]   r_depth1;   // infinite corners already zeroed
    logic [3:0][W_WT-1:0]         r_weight1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_flags1  <= n_flags1;
            r_depth1  <= n_depth1;
            r_weight1 <= n_weight1;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // corner products and finite-corner sum
    logic [3:0][W_PROD-1:0]       n_prod2;
    logic [W_SUM-1:0]             n_sum2;
    dbs_pkg::t_front_flags        r_flags2;
    logic [3:0][W_PROD-1:0]       r_prod2;
    logic [W_SUM-1:0]             r_sum2;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_prod2[i] = W_PROD'(r_depth1[i]) * W_PROD'(r_weight1[i]);
        end
    end

    assign n_sum2 = {2'b00, r_depth1[0]} + {2'b00, r_depth1[1]}
                  + {2'b00, r_depth1[2]} + {2'b00, r_depth1[3]};

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_flags2 <= r_flags1;
            r_prod2  <= n_prod2;
            r_sum2   <= n_sum2;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // bilinear accumulate, and sum/3 by reciprocal multiply
    logic [W_ACC-1:0]             n_acc3;
    logic [W_D3P-1:0]             div3_prod;
    dbs_pkg::t_front_flags        r_flags3;
    logic [W_ACC-1:0]             r_acc3;
    logic [W_SUM-1:0]             r_sum3;
    logic [W_SUM-1:0]             r_third3;

    assign n_acc3 = {2'b00, r_prod2[0]} + {2'b00, r_prod2[1]}
                  + {2'b00, r_prod2[2]} + {2'b00, r_prod2[3]};
    assign div3_prod = W_D3P'(r_sum2) * W_D3P'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_flags3 <= r_flags2;
            r_acc3   <= n_acc3;
            r_sum3   <= r_sum2;
            r_third3 <= div3_prod[K3 +: W_SUM];
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [W_SUM-1:0]             mean;
    logic [DEPTH_BITS-1:0]        n_depth4;
    logic                         n_fallback4;
    logic [DEPTH_BITS-1:0]        r_depth4;
    logic                         r_oob4;
    logic                         r_fallback4;

    // mean of the finite corners, by count
    always_comb begin
        case (r_flags3.finite_cnt)
            3'd0:    mean = {W_SUM{1'b1}};
            3'd1:    mean = r_sum3;
            3'd2:    mean = r_sum3 >> 1;
            3'd3:    mean = r_third3;
            default: mean = r_sum3 >> 2;
        endcase
    end

    always_comb begin
        if (r_flags3.out_of_image) begin
            n_depth4    = '0;
            n_fallback4 = 1'b0;
        end else if (r_flags3.any_inf) begin
            n_depth4    = mean[DEPTH_BITS-1:0];
            n_fallback4 = 1'b1;
        end else begin
            n_depth4    = r_acc3[2*COORD_FRAC_BITS +: DEPTH_BITS];
            n_fallback4 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_depth4    <= n_depth4;
            r_oob4      <= r_flags3.out_of_image;
            r_fallback4 <= n_fallback4;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = W_OUT'(r_depth4);
    assign m_axis_tuser[dbs_pkg::USER_OUT_OF_IMAGE]  = r_oob4;
    assign m_axis_tuser[dbs_pkg::USER_USED_FALLBACK] = r_fallback4;

endmodule

`default_nettype wire

// File: rtl/dbs_checker.sv
// Port-level assertions for the depth bilinear sampler, bound to the top level.
`default_nettype none

module dbs_checker #(
    parameter int DEPTH_BITS = 24
) (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   s_axis_tvalid,
    input wire logic                                   s_axis_tready,
    input wire logic [((2*dbs_pkg::COORD_BITS+4*DEPTH_BITS+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                                   m_axis_tvalid,
    input wire logic                                   m_axis_tready,
    input wire logic [((DEPTH_BITS+7)/8)*8-1:0]        m_axis_tdata,
    input wire logic [dbs_pkg::USER_BITS-1:0]          m_axis_tuser
);

    logic in_req;
    assign in_req = s_axis_tvalid && s_axis_tready;

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // outside the image: depth zero, no fallback
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[dbs_pkg::USER_OUT_OF_IMAGE] |->
            m_axis_tdata[DEPTH_BITS-1:0] == '0
            && !m_axis_tuser[dbs_pkg::USER_USED_FALLBACK])
        else $error("out-of-image result not clean");

    // infinite output only comes from the fallback path
    a_inf_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (&m_axis_tdata[DEPTH_BITS-1:0]) |->
            m_axis_tuser[dbs_pkg::USER_USED_FALLBACK])
        else $error("infinite depth without fallback");

    // negative x reaches the output as out-of-image when the output does not stall
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req && s_axis_tdata[dbs_pkg::COORD_BITS-1]
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=>
            m_axis_tvalid && m_axis_tuser[dbs_pkg::USER_OUT_OF_IMAGE])
        else $error("request lost or late in pipeline");

endmodule

bind depth_bilinear_sampler_unit dbs_checker #(
    .DEPTH_BITS (DEPTH_BITS)
) u_dbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
